FILE: hdl/flat_json_string_pair_parser_macros.svh
// Assertion macros shared by the string pair parser modules.
// Uses the clk and rst signals of the module that expands them.
`ifndef FLAT_JSON_STRING_PAIR_PARSER_MACROS_SVH
`define FLAT_JSON_STRING_PAIR_PARSER_MACROS_SVH

// same-cycle implication
`define FJSP_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FJSP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/fjsp_pkg.sv
// Types and constants of the flat JSON string pair parser.
// No dependencies.
package fjsp_pkg;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [2:0] RAW_COUNT = 3'd4;

  typedef enum logic [3:0] {
    PH_WAIT_OPEN,
    PH_AFTER_OPEN,
    PH_BEFORE_KEY,
    PH_STRING,
    PH_ESCAPE,
    PH_RAW,
    PH_AFTER_KEY,
    PH_BEFORE_VALUE,
    PH_AFTER_VALUE,
    PH_FINISHED
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_COLON,
    ERR_SEP,
    ERR_QUOTE,
    ERR_ESCAPE,
    ERR_UNTERM
  } err_t;

  typedef enum logic [1:0] {
    ACT_CHAR,
    ACT_UESC,
    ACT_STR_DONE,
    ACT_STATUS
  } act_kind_t;

  typedef struct packed {
    act_kind_t  kind;
    logic [7:0] ch;
    logic       side;
    err_t       err;
  } action_t;

endpackage

FILE: hdl/fjsp_in_if.sv
// Input channel of the string pair parser: one text byte or end marker.
// No dependencies.
interface fjsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source(output valid, text_byte, end_of_text, input ready);
  modport sink(input valid, text_byte, end_of_text, output ready);
endinterface

FILE: hdl/fjsp_out_if.sv
// Result channel of the string pair parser.
// No dependencies.
interface fjsp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       in_value;
  logic       string_done;
  logic       object_done;
  logic [2:0] error_code;
  logic       run_last;

  modport source(output valid, out_char, char_valid, in_value, string_done,
                 object_done, error_code, run_last, input ready);
  modport sink(input valid, out_char, char_valid, in_value, string_done,
               object_done, error_code, run_last, output ready);
endinterface

FILE: hdl/fjsp_queue.sv
// Action queue between parser front and result back end.
// Depends on fjsp_pkg and the assertion macro header.
`include "flat_json_string_pair_parser_macros.svh"

module fjsp_queue import fjsp_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  action_t wr_data,
  output logic    full,
  output logic    head_valid,
  output action_t head,
  input  logic    pop
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  action_t           mem [DEPTH];
  logic [IDX_W-1:0]  wr_ptr;
  logic [IDX_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `FJSP_ASSERT_IMPL(a_no_overflow, push, count != CNT_W'(DEPTH), "push into full queue")
  `FJSP_ASSERT_IMPL(a_no_underflow, pop, count != '0, "pop from empty queue")
  `FJSP_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1, "count did not rise")

endmodule

FILE: hdl/fjsp_front.sv
// Parser front: accepts text items, tracks the object grammar, queues actions.
// Depends on fjsp_pkg and fjsp_in_if.
module fjsp_front import fjsp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  fjsp_in_if.sink   text,
  input  logic      full,
  output logic      push,
  output action_t   act
);

  phase_t     phase, phase_next;
  logic [2:0] raw_left, raw_left_next;
  logic       side, side_next;
  err_t       final_err, final_err_next;

  logic       accept;
  logic       eot;
  logic [7:0] b;
  logic       ws;

  assign text.ready = !full && !rst;
  assign accept     = text.valid && text.ready;
  assign eot        = text.end_of_text;
  assign b          = text.text_byte;
  assign ws         = (b == CH_SPACE) || (b >= 8'd9 && b <= 8'd13);

  function automatic logic [7:0] unescape(input logic [7:0] e);
    case (e)
      8'h62:   unescape = 8'd8;
      8'h66:   unescape = 8'd12;
      8'h6E:   unescape = 8'd10;
      8'h72:   unescape = 8'd13;
      8'h74:   unescape = 8'd9;
      default: unescape = e;
    endcase
  endfunction

  // next state
  always_comb begin
    phase_next     = phase;
    raw_left_next  = raw_left;
    side_next      = side;
    final_err_next = final_err;
    if (accept) begin
      case (phase)
        PH_WAIT_OPEN: begin
          if (eot || (!ws && b != CH_LBRACE)) begin
            phase_next     = PH_FINISHED;
            final_err_next = ERR_NONE;
          end else if (b == CH_LBRACE) begin
            phase_next = PH_AFTER_OPEN;
          end
        end
        PH_AFTER_OPEN, PH_BEFORE_KEY, PH_BEFORE_VALUE: begin
          if (eot) begin
            phase_next     = PH_FINISHED;
            final_err_next = ERR_QUOTE;
          end else if (ws) begin
          end else if (b == CH_RBRACE && phase == PH_AFTER_OPEN) begin
            phase_next     = PH_FINISHED;
            final_err_next = ERR_NONE;
          end else if (b == CH_QUOTE) begin
            side_next  = (phase == PH_BEFORE_VALUE);
            phase_next = PH_STRING;
          end else begin
            phase_next     = PH_FINISHED;
            final_err_next = ERR_QUOTE;
          end
        end
        PH_STRING: begin
          if (eot) begin
            phase_next     = PH_FINISHED;
            final_err_next = ERR_UNTERM;
          end else if (b == CH_BSLASH) begin
            phase_next = PH_ESCAPE;
          end else if (b == CH_QUOTE) begin
            phase_next = side ? PH_AFTER_VALUE : PH_AFTER_KEY;
          end
        end
        PH_ESCAPE: begin
          if (eot) begin
            phase_next     = PH_FINISHED;
            final_err_next = ERR_ESCAPE;
          end else if (b == CH_U) begin
            raw_left_next = RAW_COUNT;
            phase_next    = PH_RAW;
          end else begin
            phase_next = PH_STRING;
          end
        end
        PH_RAW: begin
          if (eot) begin
            phase_next     = PH_FINISHED;
            final_err_next = ERR_UNTERM;
          end else if (raw_left <= 3'd1) begin
            raw_left_next = '0;
            phase_next    = PH_STRING;
          end else begin
            raw_left_next = raw_left - 1'b1;
          end
        end
        PH_AFTER_KEY: begin
          if (eot || (!ws && b != CH_COLON)) begin
            phase_next     = PH_FINISHED;
            final_err_next = ERR_COLON;
          end else if (b == CH_COLON) begin
            phase_next = PH_BEFORE_VALUE;
          end
        end
        PH_AFTER_VALUE: begin
          if (eot || (!ws && b != CH_RBRACE && b != CH_COMMA)) begin
            phase_next     = PH_FINISHED;
            final_err_next = ERR_SEP;
          end else if (b == CH_RBRACE) begin
            phase_next     = PH_FINISHED;
            final_err_next = ERR_NONE;
          end else if (b == CH_COMMA) begin
            phase_next = PH_BEFORE_KEY;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // queued actions
  always_comb begin
    push     = 1'b0;
    act.kind = ACT_CHAR;
    act.ch   = b;
    act.side = side;
    act.err  = final_err_next;
    if (accept) begin
      if (phase_next == PH_FINISHED) begin
        push     = (phase != PH_FINISHED) || eot;
        act.kind = ACT_STATUS;
      end else begin
        case (phase)
          PH_STRING: begin
            if (b == CH_QUOTE) begin
              push     = 1'b1;
              act.kind = ACT_STR_DONE;
            end else if (b != CH_BSLASH) begin
              push = 1'b1;
            end
          end
          PH_ESCAPE: begin
            push = 1'b1;
            if (b == CH_U) begin
              act.kind = ACT_UESC;
            end else begin
              act.ch = unescape(b);
            end
          end
          PH_RAW: begin
            push = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_WAIT_OPEN;
      raw_left  <= '0;
      side      <= 1'b0;
      final_err <= ERR_NONE;
    end else begin
      phase     <= phase_next;
      raw_left  <= raw_left_next;
      side      <= side_next;
      final_err <= final_err_next;
    end
  end

endmodule

FILE: hdl/fjsp_back.sv
// Result back end: expands queued actions into result items.
// Depends on fjsp_pkg, fjsp_out_if and the assertion macro header.
`include "flat_json_string_pair_parser_macros.svh"

module fjsp_back import fjsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  action_t    head,
  input  logic       head_valid,
  output logic       pop,
  fjsp_out_if.source result
);

  logic       load;
  logic       half;
  logic [7:0] ch;
  logic       cv, iv, sd, od, rl;
  logic [2:0] ec;

  assign load = !result.valid || result.ready;
  assign pop  = load && head_valid && !(head.kind == ACT_UESC && !half);

  always_comb begin
    ch = '0;
    cv = 1'b0;
    iv = 1'b0;
    sd = 1'b0;
    od = 1'b0;
    ec = ERR_NONE;
    rl = 1'b1;
    case (head.kind)
      ACT_CHAR: begin
        ch = head.ch;
        cv = 1'b1;
        iv = head.side;
      end
      ACT_UESC: begin
        ch = half ? CH_U : CH_BSLASH;
        cv = 1'b1;
        iv = head.side;
        rl = half;
      end
      ACT_STR_DONE: begin
        iv = head.side;
        sd = 1'b1;
      end
      default: begin
        od = (head.err == ERR_NONE);
        ec = head.err;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      half         <= 1'b0;
    end else if (load) begin
      result.valid <= head_valid;
      if (head_valid && head.kind == ACT_UESC) begin
        half <= !half;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      result.out_char    <= ch;
      result.char_valid  <= cv;
      result.in_value    <= iv;
      result.string_done <= sd;
      result.object_done <= od;
      result.error_code  <= ec;
      result.run_last    <= rl;
    end
  end

  `FJSP_ASSERT_IMPL(a_half_on_uesc, half, head_valid && head.kind == ACT_UESC, "split without escape")
  `FJSP_ASSERT_IMPL(a_first_half, result.valid && !result.run_last,
                    result.char_valid && result.out_char == CH_BSLASH, "bad non-final result")
  `FJSP_ASSERT_IMPL(a_status_clean, result.valid && result.object_done,
                    result.error_code == ERR_NONE && !result.char_valid, "bad status result")

endmodule

FILE: hdl/flat_json_string_pair_parser.sv
// Streaming parser for a flat JSON object of string keys and values. The block takes one
// text byte per cycle and returns the decoded characters of each string, a closing-quote
// mark per string and a final status item (object done or an error code, sticky until
// reset), repeated for each later end marker. Results pass through the action queue and
// the registered result port; a byte gives one result or none, except the 'u' of a \u
// escape, which gives two. The input stalls only when the QUEUE_DEPTH-entry action queue
// between the parser front and the result back end is full.
// Depends on fjsp_pkg, fjsp_in_if, fjsp_out_if, fjsp_queue, fjsp_front and fjsp_back.
module flat_json_string_pair_parser import fjsp_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  fjsp_in_if.sink    text,
  fjsp_out_if.source result
);

  logic    push;
  logic    full;
  logic    pop;
  logic    head_valid;
  action_t act;
  action_t head;

  fjsp_front u_front (
    .clk  (clk),
    .rst  (rst),
    .text (text),
    .full (full),
    .push (push),
    .act  (act)
  );

  fjsp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_data    (act),
    .full       (full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  fjsp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .result     (result)
  );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for flat_json_string_pair_parser: streams one text, in most runs
// a long flat object, predicts every result item in step with the accepted text and compares
// field by field. Depends on fjsp_pkg, fjsp_in_if, fjsp_out_if and the parser RTL.
module testbench;
  import fjsp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int QUIET_FROM   = 800;
  localparam int QUIET_TO     = 1300;
  localparam int IDLE_PCT     = 13;
  localparam int BODY_ITEMS   = 1540;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       in_value;
    logic       string_done;
    logic       object_done;
    err_t       error_code;
    logic       run_last;
  } parse_result_t;

  logic clk;
  logic rst;

  fjsp_in_if  text_ch();
  fjsp_out_if res_ch();

  flat_json_string_pair_parser dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (res_ch)
  );

  text_item_t    text_pending[$];
  parse_result_t expected_results[$];
  parse_result_t step_out[$];

  // parser state mirror
  phase_t     parse_ph;
  logic [2:0] raw_left;
  logic       val_side;
  logic       fin_ok;
  err_t       fin_err;

  logic in_fire         = 1'b0;
  int   cycle_count     = 0;
  int   mismatch_count  = 0;
  int   items_taken     = 0;
  int   results_checked = 0;
  int   strings_closed  = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------- prediction ----------------

  function automatic logic is_blank(logic [7:0] b);
    return b == CH_SPACE || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic [7:0] escape_value(logic [7:0] e);
    case (e)
      "b": return 8'd8;
      "f": return 8'd12;
      "n": return 8'd10;
      "r": return 8'd13;
      "t": return 8'd9;
      default: return e;
    endcase
  endfunction

  function automatic void add_step(parse_result_t r);
    step_out.insert(step_out.size(), r);
  endfunction

  function automatic void emit_char(logic [7:0] c);
    add_step('{out_char: c, char_valid: 1'b1, in_value: val_side,
               string_done: 1'b0, object_done: 1'b0,
               error_code: ERR_NONE, run_last: 1'b0});
  endfunction

  function automatic void emit_status(logic ok, err_t e);
    add_step('{out_char: 8'h00, char_valid: 1'b0, in_value: 1'b0,
               string_done: 1'b0, object_done: ok,
               error_code: e, run_last: 1'b0});
  endfunction

  function automatic void close_object(logic ok, err_t e);
    parse_ph = PH_FINISHED;
    fin_ok   = ok;
    fin_err  = e;
    emit_status(ok, e);
  endfunction

  function automatic void predict_item(logic [7:0] b, logic eot);
    step_out.delete();
    case (parse_ph)
      PH_FINISHED: begin
        if (eot) emit_status(fin_ok, fin_err);
      end
      PH_WAIT_OPEN: begin
        if (eot) close_object(1'b1, ERR_NONE);
        else if (b == CH_LBRACE) parse_ph = PH_AFTER_OPEN;
        else if (!is_blank(b)) close_object(1'b1, ERR_NONE);
      end
      PH_AFTER_OPEN, PH_BEFORE_KEY, PH_BEFORE_VALUE: begin
        if (eot) close_object(1'b0, ERR_QUOTE);
        else if (!is_blank(b)) begin
          if (b == CH_RBRACE && parse_ph == PH_AFTER_OPEN) close_object(1'b1, ERR_NONE);
          else if (b == CH_QUOTE) begin
            val_side = (parse_ph == PH_BEFORE_VALUE);
            parse_ph = PH_STRING;
          end else close_object(1'b0, ERR_QUOTE);
        end
      end
      PH_STRING: begin
        if (eot) close_object(1'b0, ERR_UNTERM);
        else if (b == CH_BSLASH) parse_ph = PH_ESCAPE;
        else if (b == CH_QUOTE) begin
          add_step('{out_char: 8'h00, char_valid: 1'b0, in_value: val_side,
                     string_done: 1'b1, object_done: 1'b0,
                     error_code: ERR_NONE, run_last: 1'b0});
          parse_ph = val_side ? PH_AFTER_VALUE : PH_AFTER_KEY;
        end else emit_char(b);
      end
      PH_ESCAPE: begin
        if (eot) close_object(1'b0, ERR_ESCAPE);
        else if (b == CH_U) begin
          emit_char(CH_BSLASH);
          emit_char(CH_U);
          raw_left = RAW_COUNT;
          parse_ph = PH_RAW;
        end else begin
          emit_char(escape_value(b));
          parse_ph = PH_STRING;
        end
      end
      PH_RAW: begin
        if (eot) close_object(1'b0, ERR_UNTERM);
        else begin
          emit_char(b);
          if (raw_left <= 3'd1) begin
            raw_left = 3'd0;
            parse_ph = PH_STRING;
          end else raw_left = raw_left - 3'd1;
        end
      end
      PH_AFTER_KEY: begin
        if (eot) close_object(1'b0, ERR_COLON);
        else if (b == CH_COLON) parse_ph = PH_BEFORE_VALUE;
        else if (!is_blank(b)) close_object(1'b0, ERR_COLON);
      end
      PH_AFTER_VALUE: begin
        if (eot) close_object(1'b0, ERR_SEP);
        else if (b == CH_RBRACE) close_object(1'b1, ERR_NONE);
        else if (b == CH_COMMA) parse_ph = PH_BEFORE_KEY;
        else if (!is_blank(b)) close_object(1'b0, ERR_SEP);
      end
      default: begin
      end
    endcase
    if (step_out.size() > 0) step_out[step_out.size() - 1].run_last = 1'b1;
    foreach (step_out[i]) expected_results.insert(expected_results.size(), step_out[i]);
  endfunction

  // ---------------- checking ----------------

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                results_checked, name, got, want));
  endtask

  task automatic check_result();
    parse_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result item, char %0h status %0d",
                                res_ch.out_char, res_ch.error_code));
    end else begin
      want = expected_results.pop_front();
      check_field("out_char", res_ch.out_char, want.out_char);
      check_field("char_valid", res_ch.char_valid, want.char_valid);
      check_field("in_value", res_ch.in_value, want.in_value);
      check_field("string_done", res_ch.string_done, want.string_done);
      check_field("object_done", res_ch.object_done, want.object_done);
      check_field("error_code", res_ch.error_code, want.error_code);
      check_field("run_last", res_ch.run_last, want.run_last);
      if (want.string_done) strings_closed++;
    end
    results_checked++;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    in_fire = 1'b0;
    if (rst) begin
      parse_ph = PH_WAIT_OPEN;
      raw_left = 3'd0;
      val_side = 1'b0;
      fin_ok   = 1'b0;
      fin_err  = ERR_NONE;
    end else begin
      if (text_ch.valid && text_ch.ready) begin
        in_fire = 1'b1;
        items_taken++;
        predict_item(text_ch.text_byte, text_ch.end_of_text);
      end
      if (res_ch.valid && res_ch.ready) check_result();
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------- driving ----------------

  always @(negedge clk) begin : drive
    text_item_t nxt;
    logic       quiet;
    if (rst) begin
      text_ch.valid       <= 1'b0;
      text_ch.text_byte   <= 8'h00;
      text_ch.end_of_text <= 1'b0;
      res_ch.ready        <= 1'b0;
    end else begin
      quiet = cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;
      if (!text_ch.valid || in_fire) begin
        if (text_pending.size() > 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt = text_pending.pop_front();
          text_ch.text_byte   <= nxt.text_byte;
          text_ch.end_of_text <= nxt.end_of_text;
          text_ch.valid       <= 1'b1;
        end else text_ch.valid <= 1'b0;
      end
      res_ch.ready <= quiet || $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  // ---------------- stimulus ----------------

  task automatic put_item(logic [7:0] b, logic eot);
    text_item_t it;
    it.text_byte   = b;
    it.end_of_text = eot;
    text_pending.insert(text_pending.size(), it);
  endtask

  task automatic put_blanks();
    int n;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) begin
      if ($urandom_range(0, 5) == 0) put_item(CH_SPACE, 1'b0);
      else put_item(8'($urandom_range(9, 13)), 1'b0);
    end
  endtask

  task automatic put_escape();
    logic [7:0] e;
    put_item(CH_BSLASH, 1'b0);
    case ($urandom_range(0, 10))
      0: e = "b";
      1: e = "f";
      2: e = "n";
      3: e = "r";
      4: e = "t";
      5: e = CH_QUOTE;
      6: e = CH_BSLASH;
      7: e = "/";
      8: e = CH_U;
      default: e = 8'($urandom_range(0, 255));
    endcase
    put_item(e, 1'b0);
    if (e == CH_U) repeat (4) put_item(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic put_body();
    int         n;
    int         r;
    logic [7:0] c;
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(11, 30) : $urandom_range(0, 10);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 14) put_escape();
      else begin
        do begin
          c = (r < 30) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(32, 126));
        end while (c == CH_QUOTE || c == CH_BSLASH);
        put_item(c, 1'b0);
      end
    end
  endtask

  task automatic put_string();
    put_item(CH_QUOTE, 1'b0);
    put_body();
    put_item(CH_QUOTE, 1'b0);
  endtask

  task automatic put_pair();
    put_blanks();
    put_string();
    put_blanks();
    put_item(CH_COLON, 1'b0);
    put_blanks();
    put_string();
    put_blanks();
  endtask

  task automatic put_ending();
    int mark;
    int pick;
    case ($urandom_range(0, 7))
      0, 1: begin
        put_item(CH_RBRACE, 1'b0);
        put_blanks();
      end
      2: begin
        // trailing comma
        put_item(CH_COMMA, 1'b0);
        put_blanks();
        put_item(CH_RBRACE, 1'b0);
      end
      3, 4: begin
        mark = text_pending.size();
        put_item(CH_COMMA, 1'b0);
        put_pair();
        put_item(CH_RBRACE, 1'b0);
        pick = $urandom_range(mark, text_pending.size() - 1);
        if ($urandom_range(0, 1) == 0) begin
          while (text_pending.size() > pick) void'(text_pending.pop_back());
        end else text_pending[pick].text_byte = 8'($urandom_range(0, 255));
      end
      5: begin
        // end of text right after a backslash
        put_item(CH_COMMA, 1'b0);
        put_blanks();
        put_item(CH_QUOTE, 1'b0);
        put_body();
        put_item(CH_BSLASH, 1'b0);
      end
      6: begin
        // end of text inside the raw bytes of a \u escape
        put_item(CH_COMMA, 1'b0);
        put_item(CH_QUOTE, 1'b0);
        put_item(CH_BSLASH, 1'b0);
        put_item(CH_U, 1'b0);
        repeat ($urandom_range(0, 3)) put_item(8'($urandom_range(0, 255)), 1'b0);
      end
      default: begin
        put_blanks();
        put_item(8'($urandom_range(0, 255)), 1'b0);
      end
    endcase
    put_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic build_stimulus();
    logic [7:0] lead [30];
    logic [7:0] b;
    lead = '{8'd9, 8'd10, 8'd11, 8'd12, 8'd13, CH_SPACE, CH_LBRACE,
             CH_QUOTE, 8'h00, 8'hFF,
             CH_BSLASH, "b", CH_BSLASH, "f", CH_BSLASH, "n", CH_BSLASH, "r",
             CH_BSLASH, "t", CH_BSLASH, CH_QUOTE, CH_BSLASH, CH_U,
             CH_QUOTE, CH_BSLASH, 8'h00, 8'hFF, CH_QUOTE, CH_COLON};
    case ($urandom_range(0, 19))
      0: begin
        // no opening brace
        for (int i = 0; i < 6; i++) put_item(lead[i], 1'b0);
        do b = 8'($urandom_range(0, 255)); while (is_blank(b) || b == CH_LBRACE);
        put_item(b, 1'b0);
      end
      1: begin
        put_blanks();
        put_item(CH_LBRACE, 1'b0);
        put_blanks();
        put_item(CH_RBRACE, 1'b0);
        put_item(8'h00, 1'b1);
      end
      2: begin
        put_blanks();
        put_item(8'hFF, 1'b1);
      end
      default: begin
        foreach (lead[i]) put_item(lead[i], 1'b0);
        put_blanks();
        put_string();
        put_blanks();
        while (text_pending.size() < BODY_ITEMS) begin
          put_item(CH_COMMA, 1'b0);
          put_pair();
        end
        put_ending();
      end
    endcase
    // trailing noise once the status is final
    repeat (60) put_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    while (text_pending.size() < BODY_ITEMS + 60)
      put_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
  endtask

  initial begin
    rst = 1'b1;
    build_stimulus();
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    while (text_pending.size() > 0 || text_ch.valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d text items in, %0d result items checked, %0d strings closed",
             items_taken, results_checked, strings_closed);
    $display("final status: object_done %0b, error code %0d", fin_ok, fin_err);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
